[src/ddo_pkg.sv]
// shared types, register codes and scaling constants of the differential drive odometry block
package ddo_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_TRACK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_STEP  = 8'd3;

    localparam logic [CFG_W-1:0] RST_INV_TRACK = 24'd483660;
    localparam logic [CFG_W-1:0] RST_MIN_STEP  = 24'd1000;
    localparam logic [CFG_W-1:0] RST_MAX_STEP  = 24'd1000000;
    localparam logic [CFG_W-1:0] RST_DEF_STEP  = 24'd100000;

    // heading scale, about 2^64 / (2 pi 1e8)
    localparam logic [63:0] K_HEAD = 64'd29358905033;
    // distance scale, about 2^79 / 1e8
    localparam logic [63:0] K_DIST = 64'd6044629098073146;

    typedef struct packed {
        logic signed [31:0] wheel_vel_r;
        logic signed [31:0] wheel_vel_l;
        logic        [23:0] elapsed_us;
    } ddo_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [31:0] heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } ddo_out_t;

endpackage

[src/diff_drive_odometry.sv]
// differential drive odometry: sequencer, pose and config registers around multiplier and cordic
//
//  channel  direction  ports                          word
//  s_       in         s_valid s_ready s_data         ddo_in_t: wheel speeds, elapsed time
//  m_       out        m_valid m_ready m_data         ddo_out_t: pose and yaw quaternion
//  cfg_     in         cfg_valid cfg_ready cfg_index  24 bit register write, always ready
//                      cfg_data
//
//  a word passes through seven multiplier passes and two cordic runs of N iterations, with
//  N = min(CORDIC_ITERATIONS, 30), before m_valid; the next word is taken only once the
//  sequencer has handed the current one to the output register
//  s_ready is high only while the sequencer is idle
//  a result waits in the output register while the next word is taken; if it is still
//  waiting when that word is done, the sequencer holds until m_ready
//  synchronous reset clears the pose, the sequencer and the registers to their defaults
module diff_drive_odometry import ddo_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ddo_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ddo_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ITERS = (CORDIC_ITERATIONS > 30) ? 30 : CORDIC_ITERATIONS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TW    = 4'd1;
    localparam logic [3:0] ST_TURN1 = 4'd2;
    localparam logic [3:0] ST_TURN2 = 4'd3;
    localparam logic [3:0] ST_DIST1 = 4'd4;
    localparam logic [3:0] ST_DIST2 = 4'd5;
    localparam logic [3:0] ST_CPOS  = 4'd6;
    localparam logic [3:0] ST_MULX  = 4'd7;
    localparam logic [3:0] ST_MULY  = 4'd8;
    localparam logic [3:0] ST_CQUAT = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
                                                   input logic [46:0] mag,
                                                   input logic neg);
        logic signed [48:0] stp;
        logic signed [48:0] tot;
        logic signed [47:0] r;
        stp = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        tot = $signed({acc[47], acc}) + stp;
        if (tot[48] != tot[47]) begin
            r = tot[48] ? ACC_MIN : ACC_MAX;
        end else begin
            r = tot[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [16:0] r;
        t = $signed({v[31], v}) + 33'sd32768;
        r = 17'(t >>> 16);
        if (r > 17'sd16384) begin
            r = 17'sd16384;
        end else if (r < -17'sd16384) begin
            r = -17'sd16384;
        end
        return 16'(r);
    endfunction

    logic [3:0]  state_reg, state_next;
    logic        go_reg;

    logic [CFG_W-1:0] inv_track_reg;
    logic [CFG_W-1:0] min_step_reg;
    logic [CFG_W-1:0] max_step_reg;
    logic [CFG_W-1:0] def_step_reg;

    logic [32:0] smag_reg;
    logic [31:0] dmag_reg;
    logic        sneg_reg;
    logic        dneg_reg;
    logic [23:0] dt_reg;
    logic [47:0] p48_reg;
    logic [63:0] t1_reg;
    logic [56:0] sd_reg;
    logic [45:0] dm_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] s_reg;
    logic signed [15:0] quat_z_reg;
    logic signed [15:0] quat_w_reg;

    logic signed [47:0] x_acc_reg;
    logic signed [47:0] y_acc_reg;
    logic [31:0]        heading_reg;

    logic     m_valid_reg;
    ddo_out_t m_data_reg;

    logic               in_acc;
    logic               out_load;
    logic signed [32:0] sum33;
    logic signed [32:0] diff33;
    logic [32:0]        sum_abs;
    logic [32:0]        diff_abs;
    logic [23:0]        dt_sel;
    logic [63:0]        mul_a;
    logic [63:0]        mul_b;
    logic               mul_state;
    logic               mul_done;
    logic [127:0]       mul_prod;
    logic [31:0]        turn;
    logic [31:0]        cord_ang;
    logic               cord_done;
    logic signed [31:0] cord_cos;
    logic signed [31:0] cord_sin;
    logic signed [31:0] trig;
    logic [31:0]        trig_abs;
    logic [46:0]        step_mag;
    logic               step_neg;

    assign in_acc   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign sum33    = $signed({s_data.wheel_vel_r[31], s_data.wheel_vel_r})
                    + $signed({s_data.wheel_vel_l[31], s_data.wheel_vel_l});
    assign diff33   = $signed({s_data.wheel_vel_r[31], s_data.wheel_vel_r})
                    - $signed({s_data.wheel_vel_l[31], s_data.wheel_vel_l});
    assign sum_abs  = sum33[32] ? 33'(-sum33) : 33'(sum33);
    assign diff_abs = diff33[32] ? 33'(-diff33) : 33'(diff33);
    assign dt_sel   = (s_data.elapsed_us < min_step_reg || s_data.elapsed_us > max_step_reg)
                    ? def_step_reg : s_data.elapsed_us;

    assign trig     = (state_reg == ST_MULX) ? c_reg : s_reg;
    assign trig_abs = trig[31] ? 32'(-trig) : 32'(trig);
    assign step_mag = mul_prod[76:30];
    assign step_neg = sneg_reg ^ trig[31];
    assign turn     = mul_prod[79:48];
    assign cord_ang = (state_reg == ST_CQUAT) ? {1'b0, heading_reg[31:1]} : heading_reg;

    always_comb begin
        mul_state = 1'b1;
        unique case (state_reg)
            ST_TW: begin
                mul_a = {40'd0, inv_track_reg};
                mul_b = {40'd0, dt_reg};
            end
            ST_TURN1: begin
                mul_a = {32'd0, dmag_reg};
                mul_b = {16'd0, p48_reg};
            end
            ST_TURN2: begin
                mul_a = t1_reg;
                mul_b = K_HEAD;
            end
            ST_DIST1: begin
                mul_a = {31'd0, smag_reg};
                mul_b = {40'd0, dt_reg};
            end
            ST_DIST2: begin
                mul_a = {7'd0, sd_reg};
                mul_b = K_DIST;
            end
            ST_MULX, ST_MULY: begin
                mul_a = {18'd0, dm_reg};
                mul_b = {32'd0, trig_abs};
            end
            default: begin
                mul_state = 1'b0;
                mul_a     = '0;
                mul_b     = '0;
            end
        endcase
    end

    ddo_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg && mul_state),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ddo_cordic #(
        .ITERATIONS (ITERS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg && (state_reg == ST_CPOS || state_reg == ST_CQUAT)),
        .ang     (cord_ang),
        .done    (cord_done),
        .cos_val (cord_cos),
        .sin_val (cord_sin)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc)    state_next = ST_TW;
            ST_TW:    if (mul_done)  state_next = ST_TURN1;
            ST_TURN1: if (mul_done)  state_next = ST_TURN2;
            ST_TURN2: if (mul_done)  state_next = ST_DIST1;
            ST_DIST1: if (mul_done)  state_next = ST_DIST2;
            ST_DIST2: if (mul_done)  state_next = ST_CPOS;
            ST_CPOS:  if (cord_done) state_next = ST_MULX;
            ST_MULX:  if (mul_done)  state_next = ST_MULY;
            ST_MULY:  if (mul_done)  state_next = ST_CQUAT;
            ST_CQUAT: if (cord_done) state_next = ST_OUT;
            ST_OUT:   if (out_load)  state_next = ST_IDLE;
            default:                 state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
            inv_track_reg <= RST_INV_TRACK;
            min_step_reg  <= RST_MIN_STEP;
            max_step_reg  <= RST_MAX_STEP;
            def_step_reg  <= RST_DEF_STEP;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            heading_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            go_reg      <= (state_next != state_reg);
            m_valid_reg <= (m_valid_reg && !m_ready) || out_load;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_INV_TRACK: inv_track_reg <= cfg_data;
                    CFG_MIN_STEP:  min_step_reg  <= cfg_data;
                    CFG_MAX_STEP:  max_step_reg  <= cfg_data;
                    CFG_DEF_STEP:  def_step_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_TURN2 && mul_done) begin
                heading_reg <= dneg_reg ? heading_reg - turn : heading_reg + turn;
            end
            if (state_reg == ST_MULX && mul_done) begin
                x_acc_reg <= sat_add(x_acc_reg, step_mag, step_neg);
            end
            if (state_reg == ST_MULY && mul_done) begin
                y_acc_reg <= sat_add(y_acc_reg, step_mag, step_neg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            smag_reg <= sum_abs;
            dmag_reg <= diff_abs[31:0];
            sneg_reg <= sum33[32];
            dneg_reg <= diff33[32];
            dt_reg   <= dt_sel;
        end
        if (mul_done) begin
            if (state_reg == ST_TW)    p48_reg <= mul_prod[47:0];
            if (state_reg == ST_TURN1) t1_reg  <= mul_prod[79:16];
            if (state_reg == ST_DIST1) sd_reg  <= mul_prod[56:0];
            if (state_reg == ST_DIST2) dm_reg  <= mul_prod[109:64];
        end
        if (cord_done && state_reg == ST_CPOS) begin
            c_reg <= cord_cos;
            s_reg <= cord_sin;
        end
        if (cord_done && state_reg == ST_CQUAT) begin
            quat_z_reg <= to_q14(cord_sin);
            quat_w_reg <= to_q14(cord_cos);
        end
        if (out_load) begin
            m_data_reg.pos_x   <= x_acc_reg[47:16];
            m_data_reg.pos_y   <= y_acc_reg[47:16];
            m_data_reg.heading <= heading_reg;
            m_data_reg.quat_z  <= quat_z_reg;
            m_data_reg.quat_w  <= quat_w_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

[src/ddo_mul.sv]
// shared 64 by 64 multiplier built from four 32 by 32 partial products, accumulated one after another
module ddo_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    localparam logic [2:0] LAST = 3'd4;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   psh_reg;
    logic         pv_reg;
    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic         done_reg;

    logic [31:0]  a_limb;
    logic [31:0]  b_limb;
    logic [63:0]  pp_next;
    logic [127:0] acc_add;

    assign a_limb  = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_limb  = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp_next = a_limb * b_limb;
    assign acc_add = {64'd0, pp_reg} << {psh_reg, 5'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
                pv_reg   <= 1'b0;
            end else if (busy_reg) begin
                pv_reg  <= !cnt_reg[2];
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (!cnt_reg[2]) begin
                pp_reg  <= pp_next;
                psh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (pv_reg) begin
                acc_reg <= acc_reg + acc_add;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[src/ddo_cordic.sv]
// iterative cordic rotator giving clamped cosine and sine in q2.30 of a binary angle
module ddo_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        ang,
    output logic               done,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);

    localparam int IW = $clog2(ITERATIONS);
    localparam logic [IW-1:0] LAST = IW'(ITERATIONS - 1);
    localparam logic signed [33:0] GAIN  = 34'sd652032874;
    localparam logic signed [33:0] ONE30 = 34'sd1073741824;

    function automatic logic [29:0] atan_bam(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
        logic signed [33:0] r;
        if (v > ONE30) begin
            r = ONE30;
        end else if (v < -ONE30) begin
            r = -ONE30;
        end else begin
            r = v;
        end
        return 32'(r);
    endfunction

    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [32:0] z_reg;
    logic [1:0]         q_reg;
    logic [IW-1:0]      it_reg;
    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;

    logic [31:0]        ang_rot;
    logic [1:0]         q_start;
    logic [31:0]        rr;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [32:0] at;
    logic signed [33:0] x_next;
    logic signed [33:0] y_next;
    logic signed [32:0] z_next;
    logic signed [33:0] c_fold;
    logic signed [33:0] s_fold;

    assign ang_rot = ang + 32'h2000_0000;
    assign q_start = ang_rot[31:30];
    assign rr      = ang - {q_start, 30'd0};

    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign at = $signed({3'd0, atan_bam(5'(it_reg))});

    always_comb begin
        if (!z_reg[32]) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    always_comb begin
        case (q_reg)
            2'd0: begin
                c_fold = x_reg;
                s_fold = y_reg;
            end
            2'd1: begin
                c_fold = -y_reg;
                s_fold = x_reg;
            end
            2'd2: begin
                c_fold = -x_reg;
                s_fold = -y_reg;
            end
            default: begin
                c_fold = y_reg;
                s_fold = -x_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
                it_reg   <= '0;
            end else if (busy_reg) begin
                it_reg <= it_reg + IW'(1);
                if (it_reg == LAST) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= GAIN;
            y_reg <= '0;
            z_reg <= {rr[31], rr};
            q_reg <= q_start;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end else if (fin_reg) begin
            cos_reg <= clamp30(c_fold);
            sin_reg <= clamp30(s_fold);
        end
    end

    assign done    = done_reg;
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

[src/ddo_checker.sv]
// port level assertions for the differential drive odometry block, bound to the top level
module ddo_checker import ddo_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input ddo_out_t m_data,
    input logic     cfg_ready
);

    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after a word");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed or dropped");

    a_quat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.quat_z <= Q14_ONE) && (m_data.quat_z >= -Q14_ONE)
                 && (m_data.quat_w <= Q14_ONE) && (m_data.quat_w >= -Q14_ONE))
        else $error("quaternion component out of range");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_ready (cfg_ready)
);

[bench/tb_diff_drive_odometry.sv]
// self-checking testbench for diff_drive_odometry: random and directed ticks against a predictor
module tb_diff_drive_odometry;
    timeunit 1ns;
    timeprecision 1ps;
    import ddo_pkg::*;

    localparam int CORDIC_ITER     = 16;
    localparam int ROT_STEPS       = CORDIC_ITER > 30 ? 30 : CORDIC_ITER;
    localparam longint ROT_GAIN    = 64'sd652032874;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint POS_MAX     = 64'sd140737488355327;
    localparam longint POS_MIN     = -POS_MAX - 64'sd1;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 250;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_DEF_STEP + 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;
    localparam logic [CFG_W-1:0]     CFG_FULL     = '1;

    localparam logic [31:0] SPD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SPD_MIN = 32'h8000_0000;

    localparam longint ATAN_BAM [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    class odom_scoreboard;
        ddo_out_t         pose_q[$];
        logic [CFG_W-1:0] inv_track, min_step, max_step, def_step;
        longint           x_acc, y_acc;
        logic [31:0]      head;
        int               errors, ticks, results;

        function new();
            inv_track = RST_INV_TRACK;
            min_step  = RST_MIN_STEP;
            max_step  = RST_MAX_STEP;
            def_step  = RST_DEF_STEP;
            x_acc     = 0;
            y_acc     = 0;
            head      = '0;
            errors    = 0;
            ticks     = 0;
            results   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_INV_TRACK: inv_track = val;
                CFG_MIN_STEP:  min_step  = val;
                CFG_MAX_STEP:  max_step  = val;
                CFG_DEF_STEP:  def_step  = val;
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void rotate(input logic [31:0] ang, output longint c, output longint s);
            logic [31:0] shifted, resid;
            logic [1:0]  quad;
            longint      x, y, z, nx;
            shifted = ang + 32'h2000_0000;
            quad    = shifted[31:30];
            resid   = ang - {quad, 30'd0};
            z = $signed(resid);
            x = ROT_GAIN;
            y = 0;
            for (int i = 0; i < ROT_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ATAN_BAM[i];
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ATAN_BAM[i];
                end
                x = nx;
            end
            case (quad)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            c = clip(c, -ONE_Q30, ONE_Q30);
            s = clip(s, -ONE_Q30, ONE_Q30);
        endfunction

        function longint advance(longint acc, logic [63:0] dm, bit neg, longint trig);
            logic [63:0]  tmag;
            logic [127:0] prod;
            longint       step;
            tmag = trig < 0 ? -trig : trig;
            prod = {64'd0, dm} * {64'd0, tmag};
            step = prod[93:30];
            if (neg != (trig < 0)) step = -step;
            return clip(acc + step, POS_MIN, POS_MAX);
        endfunction

        function logic [15:0] to_q14(longint v);
            longint t;
            t = clip((v + 32768) >>> 16, -16384, 16384);
            return t[15:0];
        endfunction

        function ddo_out_t predict(ddo_in_t w);
            longint       r, l, sum, diff, c, s, sh;
            logic [63:0]  smag, dmag, dt, itw_dt, inner, turn, dm;
            logic [127:0] prod;
            ddo_out_t     o;
            r    = w.wheel_vel_r;
            l    = w.wheel_vel_l;
            sum  = r + l;
            diff = r - l;
            smag = sum < 0 ? -sum : sum;
            dmag = diff < 0 ? -diff : diff;
            dt   = w.elapsed_us;
            if (dt < min_step || dt > max_step) dt = def_step;

            itw_dt = 64'(inv_track) * dt;
            prod   = {64'd0, dmag} * {64'd0, itw_dt};
            inner  = prod[79:16];
            prod   = {64'd0, inner} * {64'd0, K_HEAD};
            turn   = prod[111:48];
            if (diff < 0) head = head - turn[31:0];
            else head = head + turn[31:0];

            prod = {64'd0, smag * dt} * {64'd0, K_DIST};
            dm   = prod[127:64];
            rotate(head, c, s);
            x_acc = advance(x_acc, dm, sum < 0, c);
            y_acc = advance(y_acc, dm, sum < 0, s);

            sh = x_acc >>> 16;
            o.pos_x = sh[31:0];
            sh = y_acc >>> 16;
            o.pos_y = sh[31:0];
            o.heading = head;
            rotate(head >> 1, c, s);
            o.quat_z = to_q14(s);
            o.quat_w = to_q14(c);
            return o;
        endfunction

        function void note_tick(ddo_in_t w);
            pose_q.push_back(predict(w));
            ticks++;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch on %s at %0t ns: got %h, expected %h", what, $time, got, want);
        endtask

        task check_pose(ddo_out_t got);
            ddo_out_t want;
            if (pose_q.size() == 0) begin
                report("unexpected word", got.heading, '0);
                return;
            end
            want = pose_q.pop_front();
            results++;
            if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
            if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
            if (got.heading !== want.heading) report("heading", got.heading, want.heading);
            if (got.quat_z !== want.quat_z)
                report("quat_z", 32'(got.quat_z), 32'(want.quat_z));
            if (got.quat_w !== want.quat_w)
                report("quat_w", 32'(got.quat_w), 32'(want.quat_w));
        endtask
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    ddo_in_t              s_data    = '0;
    logic                 m_ready   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_ready, m_valid, cfg_ready;
    ddo_out_t             m_data;

    odom_scoreboard sb;
    bit             quiet_mode  = 1'b0;
    int             idle_cycles = 0;
    int             settings    = 0;

    diff_drive_odometry #(.CORDIC_ITERATIONS(CORDIC_ITER)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_pose(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            if (!quiet_mode && $urandom_range(0, 1) == 1) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    function automatic ddo_in_t mk_tick(logic [31:0] r, logic [31:0] l, logic [23:0] dt);
        ddo_in_t w;
        w.wheel_vel_r = r;
        w.wheel_vel_l = l;
        w.elapsed_us  = dt;
        return w;
    endfunction

    function automatic logic [31:0] rand_speed();
        int k;
        k = $urandom_range(0, 9);
        if (k <= 5) return $urandom_range(0, 600 * 65536) - 300 * 65536;
        else if (k <= 7) return $urandom;
        else if (k == 8) return SPD_MAX;
        else return SPD_MIN;
    endfunction

    function automatic ddo_in_t rand_tick();
        logic [31:0] r, l;
        logic [23:0] dt;
        r = rand_speed();
        if ($urandom_range(0, 1) == 1) l = r + ($urandom_range(0, 40 * 65536) - 20 * 65536);
        else l = rand_speed();
        case ($urandom_range(0, 9))
            7: dt = 24'($urandom);
            8: begin
                case ($urandom_range(0, 3))
                    0: dt = sb.min_step - 24'd1;
                    1: dt = sb.min_step;
                    2: dt = sb.max_step;
                    default: dt = sb.max_step + 24'd1;
                endcase
            end
            9: dt = $urandom_range(0, 1) ? CFG_FULL : '0;
            default: dt = 24'($urandom_range(50000, 150000));
        endcase
        return mk_tick(r, l, dt);
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg(int lo, int hi);
        case ($urandom_range(0, 6))
            0: return '0;
            1: return CFG_FULL;
            6: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic send_tick(ddo_in_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(w);
    endtask

    task automatic push_tick(ddo_in_t w);
        send_tick(w);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pose_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(logic [CFG_W-1:0] itw, logic [CFG_W-1:0] mn,
                               logic [CFG_W-1:0] mx, logic [CFG_W-1:0] df);
        drain();
        cfg_write(CFG_INV_TRACK, itw);
        cfg_write(CFG_MIN_STEP, mn);
        cfg_write(CFG_MAX_STEP, mx);
        cfg_write(CFG_DEF_STEP, df);
        settings++;
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // window edges, extreme speeds, spin in place
        load_config(RST_INV_TRACK, RST_MIN_STEP, RST_MAX_STEP, RST_DEF_STEP);
        push_tick(mk_tick(32'd0, 32'd0, 24'd0));
        push_tick(mk_tick(32'h0064_0000, 32'h0064_0000, 24'd1000));
        push_tick(mk_tick(32'h0064_0000, 32'h0064_0000, 24'd999));
        push_tick(mk_tick(32'h0064_0000, 32'h0064_0000, 24'd1000000));
        push_tick(mk_tick(32'h0064_0000, 32'h0064_0000, 24'd1000001));
        push_tick(mk_tick(32'h0064_0000, 32'h0064_0000, CFG_FULL));
        push_tick(mk_tick(SPD_MAX, SPD_MAX, 24'd50000));
        push_tick(mk_tick(SPD_MIN, SPD_MIN, 24'd50000));
        push_tick(mk_tick(SPD_MAX, SPD_MIN, 24'd100000));
        push_tick(mk_tick(SPD_MIN, SPD_MAX, 24'd100000));
        repeat (4) push_tick(mk_tick(32'h0032_0000, 32'hFFCE_0000, 24'd100000));
        push_tick(mk_tick(32'hFFE2_0000, 32'hFFE2_0000, 24'd200000));
        push_tick(mk_tick(32'd1, 32'd0, 24'd100000));
        push_tick(mk_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd100000));

        // no turning, widest window: drive into position saturation
        load_config('0, '0, CFG_FULL, CFG_FULL);
        repeat (8) push_tick(mk_tick(SPD_MAX, SPD_MAX, CFG_FULL));
        push_tick(mk_tick(SPD_MAX, SPD_MAX, 24'd0));

        // inverted window, widest turn scale, writes to unused indexes
        load_config(CFG_FULL, CFG_FULL, '0, 24'd150000);
        cfg_write(CFG_SPARE_LO, CFG_W'($urandom));
        cfg_write(CFG_SPARE_HI, CFG_W'($urandom));
        push_tick(mk_tick(32'h0014_0000, 32'hFFEC_0000, 24'd0));
        push_tick(mk_tick(SPD_MAX, SPD_MIN, 24'd500000));
        push_tick(mk_tick(32'hFFD8_0000, 32'h000A_0000, CFG_FULL));

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0)
                load_config(RST_INV_TRACK, RST_MIN_STEP, RST_MAX_STEP, RST_DEF_STEP);
            else
                load_config(pick_reg(100000, 2000000), pick_reg(0, 50000),
                            pick_reg(100000, 2000000), pick_reg(1000, 200000));
            quiet_mode = (ph == RAND_PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                push_tick(rand_tick());
                if (!quiet_mode && ((ph == 0 && n == 100) || $urandom_range(0, 199) == 0))
                    drain();
            end
        end

        s_valid <= 1'b0;
        while (sb.pose_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d ticks and %0d checked poses over %0d register settings",
                 sb.ticks, sb.results, settings);
        $display("including step window edges, inverted window, heading wrap and saturation");
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/ddo_pkg.sv
src/ddo_mul.sv
src/ddo_cordic.sv
src/diff_drive_odometry.sv
src/ddo_checker.sv
bench/tb_diff_drive_odometry.sv
